/* rtl/yt_pkg.sv */
// Shared types and constants for the Young tableau priority queue.
`timescale 1ns / 1ps

package yt_pkg;

   localparam int SIDE_DEFAULT      = 4;
   localparam int KEY_WIDTH_DEFAULT = 16;

   localparam int FUNC_W     = 2;
   localparam int KEY_PORT_W = 16;
   localparam int POS_W      = 2;
   localparam int STATUS_W   = 2;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INSERT  = 2'd0,
      FUNC_EXTRACT = 2'd1,
      FUNC_DELETE  = 2'd2
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_OVERFLOW = 2'd1,
      STATUS_EMPTY    = 2'd2
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;
      logic ins_step;
      logic sink_load;
      logic sink_step;
      logic rsp_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic go_insert;
      logic go_sink;
      logic ins_done;
      logic sink_down;
      logic sink_stop;
   } sts_type;

endpackage

/* rtl/yt_ctrl.sv */
// Sequencer for insert, hole sinking and response handoff.
`timescale 1ns / 1ps

module yt_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output yt_pkg::cmd_type  cmd,
   input  yt_pkg::sts_type  sts
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INSERT,
      ST_LOAD,
      ST_SINK,
      ST_DONE
   } state_type;

   state_type state_ff;
   logic      req_ready_ff;
   logic      rsp_valid_ff;
   logic      slot_free;

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE:   cmd.start     = req_valid && req_ready_ff;
         ST_INSERT: cmd.ins_step  = 1'b1;
         ST_LOAD:   cmd.sink_load = 1'b1;
         ST_SINK:   cmd.sink_step = 1'b1;
         ST_DONE:   cmd.rsp_load  = slot_free;
         default:   cmd           = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         // A response loaded into a free slot keeps valid high even if the old one leaves.
         if (state_ff == ST_DONE && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid && req_ready_ff) begin
                  req_ready_ff <= 1'b0;
                  if (sts.go_insert) begin
                     state_ff <= ST_INSERT;
                  end else if (sts.go_sink) begin
                     state_ff <= ST_LOAD;
                  end else begin
                     state_ff <= ST_DONE;
                  end
               end
            end
            ST_INSERT: begin
               if (sts.ins_done) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_LOAD: begin
               state_ff <= ST_SINK;
            end
            ST_SINK: begin
               if (sts.sink_down) begin
                  state_ff <= ST_LOAD;
               end else if (sts.sink_stop) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (slot_free) begin
                  req_ready_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

/* rtl/yt_dpath.sv */
// Tableau storage, row buffers, insert and sink logic, and response registers.
`timescale 1ns / 1ps

module yt_dpath #(
   parameter int SIDE      = yt_pkg::SIDE_DEFAULT,
   parameter int KEY_WIDTH = yt_pkg::KEY_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  yt_pkg::cmd_type                 cmd,
   output yt_pkg::sts_type                 sts,
   input  logic [yt_pkg::FUNC_W-1:0]       req_func,
   input  logic [yt_pkg::KEY_PORT_W-1:0]   req_key,
   input  logic [yt_pkg::POS_W-1:0]        req_row,
   input  logic [yt_pkg::POS_W-1:0]        req_col,
   output logic [yt_pkg::KEY_PORT_W-1:0]   rsp_result_key,
   output logic [yt_pkg::STATUS_W-1:0]     rsp_status,
   output logic                            rsp_now_empty
);

   localparam int RW  = $clog2(SIDE);
   localparam int KW  = KEY_WIDTH;
   localparam int KPW = yt_pkg::KEY_PORT_W;
   localparam logic [RW-1:0] LAST = RW'(SIDE - 1);

   typedef logic [SIDE-1:0][KW-1:0] row_type;
   typedef logic [SIDE-1:0]         flag_row_type;

   // Keys live in a row-wide memory; occupancy lives in flip-flops.
   row_type             key_mem [SIDE];
   row_type             rd_a_ff, rd_b_ff;
   row_type             cur_ff, cur_in, nxt_ff, nxt_in;
   row_type             wr_data, ins_row, sink_row;
   logic                wr_en;
   flag_row_type        full_ff [SIDE];
   flag_row_type        full_in [SIDE];
   flag_row_type        ins_full;

   logic [RW-1:0]       r_ff, r_in, c_ff, c_in;
   logic [RW-1:0]       r_nx, c_nx, rd_addr_a, rd_addr_b, start_r, start_c;
   logic [KW-1:0]       carry_ff, carry_in, result_ff, result_in, ins_carry;
   yt_pkg::status_type  status_ff, status_in;
   logic                grab_ff, grab_in;

   logic [KPW-1:0]                  rsp_key_ff;
   logic [yt_pkg::STATUS_W-1:0]     rsp_status_ff;
   logic                            rsp_empty_ff;

   logic is_insert, is_extract, is_delete, pos_ok, full00;
   logic ins_hit, ins_placed;
   logic has_right, has_down, go_down, go_right;

   // Request decode.
   assign full00     = full_ff[0][0];
   assign is_insert  = (req_func == yt_pkg::FUNC_INSERT);
   assign is_extract = (req_func == yt_pkg::FUNC_EXTRACT);
   assign is_delete  = (req_func == yt_pkg::FUNC_DELETE);
   assign pos_ok     = (int'(req_row) < SIDE) && (int'(req_col) < SIDE);
   assign start_r    = is_delete ? RW'(req_row) : '0;
   assign start_c    = is_delete ? RW'(req_col) : '0;

   // Insert: first empty cell or first larger key in the current row.
   always_comb begin
      ins_row    = rd_a_ff;
      ins_full   = full_ff[r_ff];
      ins_carry  = carry_ff;
      ins_hit    = 1'b0;
      ins_placed = 1'b0;
      for (int i = 0; i < SIDE; i++) begin
         if (!ins_hit) begin
            if (!full_ff[r_ff][i]) begin
               ins_row[i]  = carry_ff;
               ins_full[i] = 1'b1;
               ins_hit     = 1'b1;
               ins_placed  = 1'b1;
            end else if (carry_ff < rd_a_ff[i]) begin
               ins_row[i] = carry_ff;
               ins_carry  = rd_a_ff[i];
               ins_hit    = 1'b1;
            end
         end
      end
   end

   // Sink: pull the smaller neighbor into the hole, right wins ties.
   assign c_nx      = (c_ff == LAST) ? '0 : c_ff + 1'b1;
   assign r_nx      = (r_ff == LAST) ? '0 : r_ff + 1'b1;
   assign has_right = (c_ff != LAST) && full_ff[r_ff][c_nx];
   assign has_down  = (r_ff != LAST) && full_ff[r_nx][c_ff];
   assign go_down   = has_down && (!has_right || (nxt_ff[c_ff] < cur_ff[c_nx]));
   assign go_right  = has_right && !go_down;

   always_comb begin
      sink_row = cur_ff;
      if (go_down) begin
         sink_row[c_ff] = nxt_ff[c_ff];
      end else if (go_right) begin
         sink_row[c_ff] = cur_ff[c_nx];
      end
   end

   always_comb begin
      sts.go_insert = is_insert;
      sts.go_sink   = (is_extract && full00) || (is_delete && pos_ok);
      sts.ins_done  = ins_placed || (r_ff == LAST);
      sts.sink_down = go_down;
      sts.sink_stop = !go_down && !go_right;
   end

   always_comb begin
      r_in      = r_ff;
      c_in      = c_ff;
      carry_in  = carry_ff;
      result_in = result_ff;
      status_in = status_ff;
      grab_in   = grab_ff;
      full_in   = full_ff;
      cur_in    = cur_ff;
      nxt_in    = nxt_ff;
      wr_en     = 1'b0;
      wr_data   = ins_row;
      if (cmd.start) begin
         r_in      = start_r;
         c_in      = start_c;
         carry_in  = KW'(req_key);
         result_in = '0;
         status_in = (is_extract && !full00) ? yt_pkg::STATUS_EMPTY : yt_pkg::STATUS_OK;
         grab_in   = is_extract && full00;
         if (sts.go_sink) begin
            full_in[start_r][start_c] = 1'b0;
         end
      end
      if (cmd.ins_step) begin
         wr_en         = 1'b1;
         wr_data       = ins_row;
         full_in[r_ff] = ins_full;
         carry_in      = ins_carry;
         if (!ins_placed) begin
            if (r_ff == LAST) begin
               result_in = ins_carry;
               status_in = yt_pkg::STATUS_OVERFLOW;
            end else begin
               r_in = r_nx;
            end
         end
      end
      if (cmd.sink_load) begin
         cur_in = rd_a_ff;
         nxt_in = rd_b_ff;
         if (grab_ff) begin
            result_in = rd_a_ff[0];
            grab_in   = 1'b0;
         end
      end
      if (cmd.sink_step) begin
         if (go_down) begin
            wr_en                = 1'b1;
            wr_data              = sink_row;
            full_in[r_ff][c_ff]  = 1'b1;
            full_in[r_nx][c_ff]  = 1'b0;
            r_in                 = r_nx;
         end else if (go_right) begin
            cur_in               = sink_row;
            full_in[r_ff][c_ff]  = 1'b1;
            full_in[r_ff][c_nx]  = 1'b0;
            c_in                 = c_nx;
         end else begin
            wr_en   = 1'b1;
            wr_data = sink_row;
         end
      end
   end

   // Reads follow the next row index so the registered read data lines up with the row register.
   assign rd_addr_a = r_in;
   assign rd_addr_b = (r_in == LAST) ? '0 : r_in + 1'b1;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[r_ff] <= wr_data;
      end
      rd_a_ff <= key_mem[rd_addr_a];
      rd_b_ff <= key_mem[rd_addr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= '{default: '0};
      end else begin
         full_ff <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff      <= r_in;
      c_ff      <= c_in;
      carry_ff  <= carry_in;
      result_ff <= result_in;
      status_ff <= status_in;
      grab_ff   <= grab_in;
      cur_ff    <= cur_in;
      nxt_ff    <= nxt_in;
      if (cmd.rsp_load) begin
         rsp_key_ff    <= KPW'(result_ff);
         rsp_status_ff <= status_ff;
         rsp_empty_ff  <= !full00;
      end
   end

   assign rsp_result_key = rsp_key_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_now_empty  = rsp_empty_ff;

endmodule

/* rtl/young_tableau_priority_queue.sv */
// Top level of the Young tableau priority queue.
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_ready   req_func, req_key, req_row, req_col
// rsp       out        rsp_valid/rsp_ready   rsp_result_key, rsp_status, rsp_now_empty
//
// One request is worked on at a time. An insert does one row read-modify-write per
// cycle through the row-wide key memory, moving down a row until the key is placed.
// Extract and delete sink the hole by steps right and down; a step down passes
// through a load state while the next row is read.
// Reset clears all occupancy flags, so the queue is empty at once.
// A finished response waits in its output register; the next request is taken as soon
// as that register has been loaded, and only a full output register holds the block.

module young_tableau_priority_queue #(
   parameter int SIDE      = yt_pkg::SIDE_DEFAULT,
   parameter int KEY_WIDTH = yt_pkg::KEY_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [yt_pkg::FUNC_W-1:0]       req_func,
   input  logic [yt_pkg::KEY_PORT_W-1:0]   req_key,
   input  logic [yt_pkg::POS_W-1:0]        req_row,
   input  logic [yt_pkg::POS_W-1:0]        req_col,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [yt_pkg::KEY_PORT_W-1:0]   rsp_result_key,
   output logic [yt_pkg::STATUS_W-1:0]     rsp_status,
   output logic                            rsp_now_empty
);

   yt_pkg::cmd_type cmd;
   yt_pkg::sts_type sts;

   // The controller sequences each request and owns both handshakes.
   yt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // The datapath holds the tableau, the working rows and the response fields.
   yt_dpath #(
      .SIDE      (SIDE),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_func       (req_func),
      .req_key        (req_key),
      .req_row        (req_row),
      .req_col        (req_col),
      .rsp_result_key (rsp_result_key),
      .rsp_status     (rsp_status),
      .rsp_now_empty  (rsp_now_empty)
   );

endmodule
